@@ hw/rtl/lzw_pkg.sv @@
// Shared constants and controller/datapath interface types for the LZW byte compressor.
// Used by lzw_ctrl, lzw_dp and lzw_byte_compressor_unit; depends on nothing.
`default_nettype none
package lzw_pkg;
   localparam int DICT_SIZE_DEF = 4096;
   localparam int BYTE_W        = 8;
   localparam int CODE_W        = 16;
   localparam int FIRST_FREE    = 256;
   localparam int LIT_LIMIT     = 128;
   localparam logic [7:0] HDR_BIT = 8'h80;
   localparam int FIFO_DEPTH    = 4;

   typedef struct packed {
      logic ready;      // take an input transaction
      logic accept;     // latch input byte and end flag
      logic start_pend; // first byte of a stream becomes the pending match
      logic rd_en;      // read slot at probe address
      logic addr_next;  // probe the following slot
      logic take_hit;   // pending <- matched code
      logic take_miss;  // emit pending, add entry, restart match
      logic load_eoi;   // emit pending as final code of the stream
      logic push;       // push one encoded byte to the output queue
      logic clr_start;  // return stream state to reset values
      logic clr_step;   // clear one slot
   } lzw_cmd_type;

   typedef struct packed {
      logic in_last;
      logic eoi;
      logic pend_valid;
      logic hit;
      logic empty;
      logic emit_end;
      logic fifo_full;
      logic clr_end;
   } lzw_status_type;
endpackage
`default_nettype wire

@@ hw/rtl/lzw_ctrl.sv @@
// Sequencer for the LZW byte compressor: lookup, probe, emit and clearing steps.
// Depends on lzw_pkg for the command and status types.
`default_nettype none
module lzw_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   input  wire lzw_pkg::lzw_status_type status,
   output lzw_pkg::lzw_cmd_type         cmd
);
   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_COMPARE, ST_EMIT_MISS, ST_LOAD_EOI, ST_EMIT_EOI
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_end) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (!status.pend_valid) begin
                  cmd.start_pend = 1'b1;
                  state_in = status.in_last ? ST_LOAD_EOI : ST_IDLE;
               end else begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (status.hit) begin
               cmd.take_hit = 1'b1;
               state_in = status.eoi ? ST_LOAD_EOI : ST_IDLE;
            end else if (status.empty) begin
               cmd.take_miss = 1'b1;
               state_in = ST_EMIT_MISS;
            end else begin
               cmd.addr_next = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_EMIT_MISS: begin
            if (!status.fifo_full) begin
               cmd.push = 1'b1;
               if (status.emit_end) state_in = status.eoi ? ST_LOAD_EOI : ST_IDLE;
            end
         end
         ST_LOAD_EOI: begin
            cmd.load_eoi = 1'b1;
            state_in = ST_EMIT_EOI;
         end
         ST_EMIT_EOI: begin
            if (!status.fifo_full) begin
               cmd.push = 1'b1;
               if (status.emit_end) begin
                  cmd.clr_start = 1'b1;
                  state_in = ST_CLEAR;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

@@ hw/rtl/lzw_dp.sv @@
// Datapath of the LZW byte compressor: hashed dictionary memory, match state,
// code-to-byte encoder and output queue. Depends on lzw_pkg.
`default_nettype none
module lzw_dp #(
   parameter int DICT_SIZE = lzw_pkg::DICT_SIZE_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lzw_pkg::lzw_cmd_type cmd,
   output lzw_pkg::lzw_status_type   status,
   input  wire logic [7:0]           req_tdata,
   input  wire logic                 req_tlast,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tlast,
   output logic                      rsp_tuser
);
   localparam int CW     = $clog2(DICT_SIZE);
   localparam int HASH   = 2 * DICT_SIZE;
   localparam int HW     = $clog2(HASH);
   localparam int SLOT_W = 1 + CW + lzw_pkg::BYTE_W + CW;
   localparam int FD     = lzw_pkg::FIFO_DEPTH;
   localparam int PW     = $clog2(FD);

   // slot: {valid, prefix, char, code}
   logic [SLOT_W-1:0] mem [HASH];
   logic [SLOT_W-1:0] rd_ff;

   logic [7:0]    c_ff, c_in;
   logic          eoi_ff, eoi_in;
   logic [CW-1:0] pend_ff, pend_in;
   logic          pvalid_ff, pvalid_in;
   logic [CW:0]   nfree_ff, nfree_in;
   logic [HW-1:0] addr_ff, addr_in;
   logic [HW-1:0] clr_ff, clr_in;
   logic [15:0]   ecode_ff, ecode_in;
   logic [1:0]    eidx_ff, eidx_in;
   logic          efinal_ff, efinal_in;
   logic          edone_ff, edone_in;

   logic [9:0]    fifo_ff [FD];
   logic [PW-1:0] wptr_ff, rptr_ff;
   logic [PW:0]   cnt_ff;

   logic          room;
   logic [HW-1:0] raw_hash, hashed;
   logic          rd_valid;
   logic [CW-1:0] rd_prefix, rd_code;
   logic [7:0]    rd_char;
   logic [1:0]    nlen;
   logic [7:0]    ebyte;
   logic          we, pop;
   logic [HW-1:0] waddr;
   logic [SLOT_W-1:0] wdata;

   assign room = nfree_ff < (CW+1)'(DICT_SIZE);

   // fold pending code and incoming byte into a slot index below HASH
   assign raw_hash = {pend_ff, 1'b0} ^ HW'(req_tdata);
   assign hashed   = ({1'b0, raw_hash} >= (HW+1)'(HASH)) ?
                     HW'({1'b0, raw_hash} - (HW+1)'(HASH)) : raw_hash;

   assign rd_valid  = rd_ff[SLOT_W-1];
   assign rd_prefix = rd_ff[SLOT_W-2 -: CW];
   assign rd_char   = rd_ff[CW+7 -: 8];
   assign rd_code   = rd_ff[CW-1:0];

   // encoded length minus one: literal, header+1, header+2
   always_comb begin
      if (ecode_ff < 16'(lzw_pkg::LIT_LIMIT)) nlen = 2'd0;
      else if (ecode_ff[15:8] == 8'd0)        nlen = 2'd1;
      else                                    nlen = 2'd2;
      case (eidx_ff)
         2'd0:    ebyte = (nlen == 2'd0) ? ecode_ff[7:0] : (lzw_pkg::HDR_BIT | 8'(nlen));
         2'd1:    ebyte = ecode_ff[7:0];
         default: ebyte = ecode_ff[15:8];
      endcase
   end

   always_comb begin
      c_in      = c_ff;
      eoi_in    = eoi_ff;
      pend_in   = pend_ff;
      pvalid_in = pvalid_ff;
      nfree_in  = nfree_ff;
      addr_in   = addr_ff;
      clr_in    = clr_ff;
      ecode_in  = ecode_ff;
      eidx_in   = eidx_ff;
      efinal_in = efinal_ff;
      edone_in  = edone_ff;
      if (cmd.accept) begin
         c_in    = req_tdata;
         eoi_in  = req_tlast;
         addr_in = hashed;
      end
      if (cmd.start_pend) begin
         pend_in   = CW'(req_tdata);
         pvalid_in = 1'b1;
      end
      if (cmd.addr_next)
         addr_in = (addr_ff == HW'(HASH-1)) ? '0 : addr_ff + 1'b1;
      if (cmd.take_hit) pend_in = rd_code;
      if (cmd.take_miss) begin
         ecode_in  = 16'(pend_ff);
         eidx_in   = 2'd0;
         efinal_in = !eoi_ff;
         edone_in  = 1'b0;
         pend_in   = CW'(c_ff);
         if (room) nfree_in = nfree_ff + 1'b1;
      end
      if (cmd.load_eoi) begin
         ecode_in  = 16'(pend_ff);
         eidx_in   = 2'd0;
         efinal_in = 1'b1;
         edone_in  = 1'b1;
      end
      if (cmd.push) eidx_in = eidx_ff + 1'b1;
      if (cmd.clr_start) begin
         pvalid_in = 1'b0;
         pend_in   = '0;
         nfree_in  = (CW+1)'(lzw_pkg::FIRST_FREE);
         clr_in    = '0;
      end
      if (cmd.clr_step) clr_in = clr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         pend_ff   <= '0;
         nfree_ff  <= (CW+1)'(lzw_pkg::FIRST_FREE);
         clr_ff    <= '0;
      end else begin
         pvalid_ff <= pvalid_in;
         pend_ff   <= pend_in;
         nfree_ff  <= nfree_in;
         clr_ff    <= clr_in;
      end
      c_ff      <= c_in;
      eoi_ff    <= eoi_in;
      addr_ff   <= addr_in;
      ecode_ff  <= ecode_in;
      eidx_ff   <= eidx_in;
      efinal_ff <= efinal_in;
      edone_ff  <= edone_in;
   end

   // dictionary slots: one write port, one registered read port
   assign we    = (cmd.take_miss && room) || cmd.clr_step;
   assign waddr = cmd.clr_step ? clr_ff : addr_ff;
   assign wdata = cmd.clr_step ? '0 : {1'b1, pend_ff, c_ff, nfree_ff[CW-1:0]};

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (cmd.rd_en) rd_ff <= mem[addr_ff];
   end

   // output queue
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_tdata  = fifo_ff[rptr_ff][9:2];
   assign rsp_tlast  = fifo_ff[rptr_ff][1];
   assign rsp_tuser  = fifo_ff[rptr_ff][0];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (cmd.push) wptr_ff <= wptr_ff + 1'b1;
         if (pop)      rptr_ff <= rptr_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(cmd.push) - (PW+1)'(pop);
      end
      if (cmd.push)
         fifo_ff[wptr_ff] <= {ebyte, efinal_ff && (eidx_ff == nlen),
                              edone_ff && (eidx_ff == nlen)};
   end

   assign status.in_last    = req_tlast;
   assign status.eoi        = eoi_ff;
   assign status.pend_valid = pvalid_ff;
   assign status.hit        = rd_valid && (rd_prefix == pend_ff) && (rd_char == c_ff);
   assign status.empty      = !rd_valid;
   assign status.emit_end   = eidx_ff == nlen;
   assign status.fifo_full  = cnt_ff == (PW+1)'(FD);
   assign status.clr_end    = clr_ff == HW'(HASH-1);
endmodule
`default_nettype wire

@@ hw/rtl/lzw_byte_compressor_unit.sv @@
// Streaming LZW byte compressor, top level: joins lzw_ctrl and lzw_dp.
// Depends on lzw_pkg, lzw_ctrl, lzw_dp.
//
// Usage:
//   req channel: one raw byte per transaction, tlast marks the final byte of a stream.
//   rsp channel: encoded bytes; tlast marks the last byte caused by an input byte,
//   tuser marks the very last byte of the stream.
//   Codes below 128 go out as one byte, larger ones as 0x80|n and n bytes, LSB first.
// Operation: one input byte at a time. A byte that hits the dictionary passes through
//   accept, slot read and compare, each extra hash probe repeating read and compare; a miss
//   then emits the encoded bytes (1 to 3), a final byte also the flush of the pending code.
// Dictionary: hashed slot memory of 2*DICT_SIZE entries, one read or write per cycle.
// Reset and every end of stream start a clearing pass over all 2*DICT_SIZE slots
//   (8192 at the default size) during which req_tready stays low.
// Results wait in a 4-entry queue; when rsp_tready is low, the block holds in its emit
//   step once the queue is full; input bytes that hit the dictionary still go through.
`default_nettype none
module lzw_byte_compressor_unit #(
   parameter int DICT_SIZE = lzw_pkg::DICT_SIZE_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,   // end_of_input
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast,   // run_last
   output logic            rsp_tuser    // [0] stream_done
);
   lzw_pkg::lzw_cmd_type    cmd;
   lzw_pkg::lzw_status_type status;

   lzw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   lzw_dp #(.DICT_SIZE(DICT_SIZE)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = cmd.ready;

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !status.fifo_full) else $error("push into full output queue");
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take_hit, cmd.take_miss, cmd.clr_step, cmd.push, cmd.accept}))
      else $error("conflicting datapath commands");
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast) else $error("stream end without run end");
`endif
endmodule
`default_nettype wire

@@ tb/lzw_checker.sv @@
// Checker for the LZW byte compressor: watches both stream channels, predicts the
// encoded byte stream and compares every rsp transaction. Depends on nothing else.
module lzw_checker #(
   parameter int DICT_SIZE = 4096
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic       req_tlast,
   input  wire logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire logic [7:0] rsp_tdata,
   input  wire logic       rsp_tlast,
   input  wire logic       rsp_tuser,
   output int              fail_count,
   output int              bytes_owed
);
   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       done;
   } coded_byte_type;

   coded_byte_type owed_q[$];
   int unsigned code_of[int unsigned];  // key {prefix, char}
   int unsigned next_code;
   logic [15:0] match_code;
   logic        match_open;

   assign bytes_owed = owed_q.size();

   function automatic void clear_dict();
      code_of.delete();
      next_code  = 256;
      match_code = '0;
      match_open = 1'b0;
   endfunction

   function automatic void push_code(logic [15:0] code, ref coded_byte_type out_q[$]);
      coded_byte_type b;
      b.last = 1'b0;
      b.done = 1'b0;
      if (code < 128) begin
         b.data = code[7:0];
         out_q.push_back(b);
      end else if (code <= 16'hFF) begin
         b.data = 8'h81;
         out_q.push_back(b);
         b.data = code[7:0];
         out_q.push_back(b);
      end else begin
         b.data = 8'h82;
         out_q.push_back(b);
         b.data = code[7:0];
         out_q.push_back(b);
         b.data = code[15:8];
         out_q.push_back(b);
      end
   endfunction

   function automatic void encode_byte(logic [7:0] c, logic eoi);
      coded_byte_type step_q[$];
      int unsigned key;
      key = {match_code, c};
      if (!match_open) begin
         match_code = {8'h00, c};
         match_open = 1'b1;
      end else if (code_of.exists(key)) begin
         match_code = code_of[key][15:0];
      end else begin
         push_code(match_code, step_q);
         if (next_code < DICT_SIZE) begin
            code_of[key] = next_code;
            next_code++;
         end
         match_code = {8'h00, c};
      end
      if (eoi) begin
         push_code(match_code, step_q);
         clear_dict();
      end
      if (step_q.size() > 0) begin
         step_q[$].last = 1'b1;
         step_q[$].done = eoi;
      end
      foreach (step_q[i]) owed_q.push_back(step_q[i]);
   endfunction

   initial begin
      fail_count = 0;
      clear_dict();
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_q.size() == 0) begin
               $display("%0t: unexpected rsp transaction data=%h last=%b user=%b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
               fail_count++;
            end else begin
               coded_byte_type e;
               e = owed_q.pop_front();
               if (e.data !== rsp_tdata || e.last !== rsp_tlast || e.done !== rsp_tuser) begin
                  $display("%0t: mismatch expected data=%h last=%b user=%b, got %h %b %b",
                           $time, e.data, e.last, e.done, rsp_tdata, rsp_tlast, rsp_tuser);
                  fail_count++;
               end
            end
         end
         // prediction after the pop so a same-cycle output is never matched to it
         if (req_tvalid && req_tready) encode_byte(req_tdata, req_tlast);
      end
   end
endmodule

@@ tb/tb_lzw_byte_compressor_unit.sv @@
// Testbench top for lzw_byte_compressor_unit: clock, reset, stream stimulus with
// random gaps and stalls, verdict. Depends on the DUT and lzw_checker.
module tb_lzw_byte_compressor_unit;
   localparam int CYCLE_LIMIT = 3000000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       rsp_tuser;
   int         fail_count;
   int         bytes_owed;
   int         cycle_count = 0;
   int         hold_cycles = 0;
   logic       hold_request = 1'b0;
   logic       no_gaps = 1'b0;

   always #1 clock = ~clock;

   lzw_byte_compressor_unit DUT (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .rsp_tuser
   );

   lzw_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .rsp_tuser,
      .fail_count, .bytes_owed
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: mostly short stalls, some long ones, stall-free stretches, long holds during one stream
   always @(posedge clock) begin
      if (hold_request && hold_cycles == 0) begin
         hold_cycles <= 400;
         rsp_tready  <= 1'b0;
      end else if (hold_cycles > 1) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else if (hold_cycles == 1) begin
         hold_cycles <= 0;
         rsp_tready  <= 1'b1;
      end else if (no_gaps) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
         hold_cycles <= $urandom_range(5, 40);
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic send_byte(logic [7:0] b, logic eoi);
      int gap;
      gap = 0;
      if (!no_gaps) gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
                                                       : $urandom_range(0, 2);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_stream(int len, int alphabet);
      for (int i = 0; i < len; i++)
         send_byte(alphabet >= 256 ? 8'($urandom_range(0, 255))
                                   : 8'($urandom_range(0, alphabet - 1)), i == len - 1);
   endtask

   task automatic drain_wait();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (bytes_owed != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int len;
      bit held;
      bit drained;
      held    = 1'b0;
      drained = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // first byte is also final; literal extremes
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);
      // repeats build long matches; codes 127/128 cross the literal limit
      for (int i = 0; i < 6; i++) send_byte(8'h00, i == 5);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b1);
      drain_wait();

      sent = 0;
      while (sent < 186) begin
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(8, 40);
         no_gaps <= ($urandom_range(0, 4) == 0);
         if (!held && sent >= 60) begin
            hold_request <= 1'b1;
            held = 1'b1;
         end
         send_stream(len, ($urandom_range(0, 2) == 0) ? 256 : $urandom_range(2, 4));
         hold_request <= 1'b0;
         sent += len;
         if (!drained && sent >= 120) begin
            drain_wait();
            drained = 1'b1;
         end
      end
      req_tvalid <= 1'b0;
      no_gaps    <= 1'b0;

      while (bytes_owed != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

@@ files.f @@
hw/rtl/lzw_pkg.sv
hw/rtl/lzw_ctrl.sv
hw/rtl/lzw_dp.sv
hw/rtl/lzw_byte_compressor_unit.sv
tb/lzw_checker.sv
tb/tb_lzw_byte_compressor_unit.sv
